### hw/rtl/btas_pkg.sv
`timescale 1ns / 1ps

package btas_pkg;

  // Architectural constants of the block transfer.
  localparam int unsigned RegCount = 16;
  localparam logic [3:0] PcIndex = 4'd15;
  localparam logic [31:0] StepBytes = 32'd4;
  localparam logic [31:0] EmptyOffset = 32'h0000_0040;
  localparam logic [31:0] WordMask = 32'hFFFF_FFFC;

  // Widths of the packed stream payloads.
  localparam int unsigned InDataWidth = 64;
  localparam int unsigned OutDataWidth = 80;

  // Controller state, one-hot.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } ctrl_state_e;

  // One decoded block transfer instruction.
  typedef struct packed {
    logic [31:0] base_address;
    logic [15:0] register_list;
    logic        ascending;
    logic        pre_index;
    logic        is_load;
    logic        write_back;
    logic        user_bank;
    logic [3:0]  base_index;
  } in_item_t;

  // One memory transfer produced by the sequencer.
  typedef struct packed {
    logic [3:0]  reg_index;
    logic [31:0] word_address;
    logic        load_access;
    logic        use_user_regs;
    logic        store_plus_four;
    logic        restore_status;
    logic        base_update;
    logic [31:0] new_base;
    logic        last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_step;
  } dp_status_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [3:0] lowest_set(input logic [RegCount-1:0] v);
    logic [3:0] idx;
    idx = '0;
    for (int i = RegCount - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

  // Index of the highest set bit; zero when no bit is set.
  function automatic logic [3:0] highest_set(input logic [RegCount-1:0] v);
    logic [3:0] idx;
    idx = '0;
    for (int i = 0; i < RegCount; i++) begin
      if (v[i]) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

endpackage

### hw/rtl/btas_ctrl.sv
`timescale 1ns / 1ps

module btas_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  btas_pkg::dp_status_t  status_i,
  output btas_pkg::ctrl_cmd_t   cmd_o
);

  btas_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  // The output register can take a new transfer when empty or being drained.
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    in_ready_o = 1'b0;
    unique case (state_q)
      btas_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = btas_pkg::ST_BUSY;
        end
      end
      btas_pkg::ST_BUSY: begin
        if (slot_free) begin
          cmd_o.step = 1'b1;
          if (status_i.last_step) begin
            state_d = btas_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = btas_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register occupancy.
  always_comb begin
    if (cmd_o.step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btas_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/btas_dp.sv
`timescale 1ns / 1ps

module btas_dp (
  input  logic                 clk_i,
  input  btas_pkg::in_item_t   item_i,
  input  btas_pkg::ctrl_cmd_t  cmd_i,
  output btas_pkg::dp_status_t status_o,
  output btas_pkg::result_t    result_o
);

  logic [31:0] addr_q;
  logic [15:0] list_q;
  logic        asc_q;
  logic        pre_q;
  logic        load_q;
  logic        user_q;
  logic        upd_q;
  logic        empty_q;
  btas_pkg::result_t result_q;

  logic [3:0]  sel_idx;
  logic [15:0] rem_list;
  logic [31:0] step_addr;
  logic [31:0] access_addr;
  logic [31:0] empty_base;
  logic        is_pc;
  logic        last_step;
  btas_pkg::result_t result_d;

  // Pick the next register in walk order and advance the address.
  always_comb begin
    sel_idx = asc_q ? btas_pkg::lowest_set(list_q) : btas_pkg::highest_set(list_q);
    rem_list = list_q & ~(16'd1 << sel_idx);
    step_addr = asc_q ? (addr_q + btas_pkg::StepBytes) : (addr_q - btas_pkg::StepBytes);
    access_addr = pre_q ? step_addr : addr_q;
    empty_base = asc_q ? (addr_q + btas_pkg::EmptyOffset)
                       : (addr_q - btas_pkg::EmptyOffset);
    is_pc = (sel_idx == btas_pkg::PcIndex);
    last_step = empty_q || (rem_list == '0);
  end

  // Build the transfer for this step.
  always_comb begin
    if (empty_q) begin
      // An empty list moves only r15 at the base and always writes back.
      result_d.reg_index = btas_pkg::PcIndex;
      result_d.word_address = addr_q & btas_pkg::WordMask;
      result_d.load_access = load_q;
      result_d.use_user_regs = 1'b0;
      result_d.store_plus_four = !load_q;
      result_d.restore_status = 1'b0;
      result_d.base_update = 1'b1;
      result_d.new_base = empty_base;
      result_d.last = 1'b1;
    end else begin
      result_d.reg_index = sel_idx;
      result_d.word_address = access_addr & btas_pkg::WordMask;
      result_d.load_access = load_q;
      result_d.use_user_regs = user_q && !(load_q && is_pc);
      result_d.store_plus_four = !load_q && is_pc;
      result_d.restore_status = user_q && load_q && is_pc;
      result_d.base_update = last_step && upd_q;
      result_d.new_base = (last_step && upd_q) ? step_addr : '0;
      result_d.last = last_step;
    end
  end

  // Working registers and the output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= item_i.base_address;
      list_q <= item_i.register_list;
      asc_q <= item_i.ascending;
      pre_q <= item_i.pre_index;
      load_q <= item_i.is_load;
      user_q <= item_i.user_bank;
      empty_q <= (item_i.register_list == '0);
      upd_q <= item_i.write_back
               && !(item_i.is_load && item_i.register_list[item_i.base_index]);
    end else if (cmd_i.step) begin
      addr_q <= step_addr;
      list_q <= rem_list;
    end
    if (cmd_i.step) begin
      result_q <= result_d;
    end
  end

  assign status_o.last_step = last_step;
  assign result_o = result_q;

endmodule

### hw/rtl/block_transfer_address_sequencer.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata / tlast contents
// s_axis    in         one block transfer instruction
// m_axis    out        one memory transfer; tlast marks the final one
//
// An instruction with N listed registers gives N transfers, one per cycle
// while m_axis is not stalled, and an empty list gives one. The input is
// loaded into the working registers before the first transfer is stepped into
// the output register, and a new instruction is taken only after the final
// step. The step address adder and register picker in the datapath, used once
// per transfer, set that pace.
// Reset clears the controller and the output valid; no memory needs clearing.
// A stall on m_axis holds the sequence; s_axis is taken only between
// instructions, even while the final transfer still waits to be taken.
module block_transfer_address_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] base_address, [47:32] register_list, [48] ascending,
  // [49] pre_index, [50] is_load, [51] write_back, [52] user_bank,
  // [56:53] base_index, [63:57] zero
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] reg_index, [35:4] word_address, [36] load_access,
  // [37] use_user_regs, [38] store_plus_four, [39] restore_status,
  // [40] base_update, [72:41] new_base, [79:73] zero
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  btas_pkg::in_item_t   item;
  btas_pkg::ctrl_cmd_t  cmd;
  btas_pkg::dp_status_t status;
  btas_pkg::result_t    result;

  // Unpack the instruction.
  assign item.base_address = s_axis_tdata[31:0];
  assign item.register_list = s_axis_tdata[47:32];
  assign item.ascending = s_axis_tdata[48];
  assign item.pre_index = s_axis_tdata[49];
  assign item.is_load = s_axis_tdata[50];
  assign item.write_back = s_axis_tdata[51];
  assign item.user_bank = s_axis_tdata[52];
  assign item.base_index = s_axis_tdata[56:53];

  btas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  btas_dp u_dp (
    .clk_i    (clk_i),
    .item_i   (item),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result)
  );

  // Pack the transfer.
  assign m_axis_tdata = {7'd0, result.new_base, result.base_update, result.restore_status,
                         result.store_plus_four, result.use_user_regs, result.load_access,
                         result.word_address, result.reg_index};
  assign m_axis_tlast = result.last;

`ifndef SYNTHESIS
  // A taken instruction keeps the input closed on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input open right after an instruction was taken");

  // A pending transfer that is not the final one means the sequence still runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input open in the middle of a sequence");

  // Writeback is reported on the final transfer only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[40] |-> m_axis_tlast)
    else $error("base update on a transfer that is not the final one");

  // The datapath steps only while the output register can take the transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !m_axis_tvalid || m_axis_tready)
    else $error("transfer overwritten before it was taken");
`endif

endmodule
